### src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the cache core. Both macros sample on the
// rising edge of clk_i and are switched off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checks a property on every clock edge outside reset.
`define LRU3C_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("%m: property failed");

// Checks that a condition always brings its consequence in the same cycle.
`define LRU3C_ASSERT_IMPL(name, ante, cons) \
  `LRU3C_ASSERT(name, (ante) |-> (cons))

`else

`define LRU3C_ASSERT(name, prop)
`define LRU3C_ASSERT_IMPL(name, ante, cons)

`endif

`endif

### src/lru3c_pkg.sv
// ----------------------------------------------------------------------------
// lru3c_pkg
// Shared types and constants of the three-way LRU set cache core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lru3c_pkg;

  // Fixed field widths of the item and result.
  localparam int VALUE_W     = 31;
  localparam int NUM_SETS_W  = 9;
  localparam int SET_INDEX_W = 8;
  localparam int ACTION_W    = 3;

  // Set count after reset.
  localparam logic [NUM_SETS_W-1:0] NUM_SETS_RST = 9'd256;

  // Queue between the front and the back.
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Result codes.
  typedef enum logic [ACTION_W-1:0] {
    ACT_FILL        = 3'd0,
    ACT_HIT_NEWEST  = 3'd1,
    ACT_HIT_REORDER = 3'd2,
    ACT_APPEND      = 3'd3,
    ACT_EVICT       = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_DIVIDE,
    FR_PUSH
  } front_state_e;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_LOOKUP
  } back_state_e;

  // Queue fill status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

### src/lru3c_queue.sv
// ----------------------------------------------------------------------------
// lru3c_queue
// Small FIFO that carries classified items from the front to the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lru3c_queue #(
  parameter int WIDTH = 39
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  logic [WIDTH-1:0]      push_data_i,
  input  logic                  pop_i,
  output logic [WIDTH-1:0]      pop_data_o,
  output lru3c_pkg::q_status_t  status_o
);

  localparam int PW = lru3c_pkg::Q_PTR_W;
  localparam int CW = lru3c_pkg::Q_CNT_W;

  logic [WIDTH-1:0] entry_q [lru3c_pkg::Q_DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;

  // Pointer and fill count update, wrapping at the queue depth.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(lru3c_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PW'(lru3c_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign pop_data_o      = entry_q[rd_ptr_q];
  assign status_o.full   = (count_q == CW'(lru3c_pkg::Q_DEPTH));
  assign status_o.empty  = (count_q == '0);

endmodule

### src/lru3c_front.sv
// ----------------------------------------------------------------------------
// lru3c_front
// Accepts an item and finds its set with a bit-serial remainder unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lru3c_front #(
  parameter int MAX_SETS = 256
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                accept_i,
  input  logic [lru3c_pkg::VALUE_W-1:0]       value_i,
  input  logic [lru3c_pkg::NUM_SETS_W-1:0]    num_sets_i,
  input  lru3c_pkg::q_status_t                q_status_i,
  output logic                                q_push_o,
  output logic [lru3c_pkg::VALUE_W+((MAX_SETS > 1) ? $clog2(MAX_SETS) : 1)-1:0] q_data_o,
  output logic                                busy_o
);

  localparam int VW  = lru3c_pkg::VALUE_W;
  localparam int SIW = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int MW  = $clog2(MAX_SETS + 1);
  localparam int DW  = (MW > lru3c_pkg::NUM_SETS_W) ? MW : lru3c_pkg::NUM_SETS_W;
  localparam int STW = $clog2(VW);

  lru3c_pkg::front_state_e state_q, state_d;

  logic [VW-1:0]  value_q, value_d;
  logic [VW-1:0]  dvd_q, dvd_d;
  logic [DW-1:0]  div_q, div_d;
  logic [DW-1:0]  rem_q, rem_d;
  logic [STW-1:0] step_q, step_d;

  logic [DW-1:0]  ns_ext;
  logic [DW-1:0]  eff_sets;
  logic [DW:0]    trial;
  logic [DW:0]    trial_sub;

  // A set count of zero or above the store size means the whole store.
  always_comb begin
    ns_ext = DW'(num_sets_i);
    if (ns_ext == '0 || ns_ext > DW'(MAX_SETS)) begin
      eff_sets = DW'(MAX_SETS);
    end else begin
      eff_sets = ns_ext;
    end
  end

  // One restoring remainder step: bring in the next dividend bit.
  assign trial     = {rem_q, dvd_q[VW-1]};
  assign trial_sub = trial - {1'b0, div_q};

  always_comb begin
    state_d  = state_q;
    value_d  = value_q;
    dvd_d    = dvd_q;
    div_d    = div_q;
    rem_d    = rem_q;
    step_d   = step_q;
    q_push_o = 1'b0;
    case (state_q)
      lru3c_pkg::FR_IDLE: begin
        if (accept_i) begin
          value_d = value_i;
          dvd_d   = value_i;
          div_d   = eff_sets;
          rem_d   = '0;
          step_d  = '0;
          state_d = lru3c_pkg::FR_DIVIDE;
        end
      end
      lru3c_pkg::FR_DIVIDE: begin
        if (trial >= {1'b0, div_q}) begin
          rem_d = trial_sub[DW-1:0];
        end else begin
          rem_d = trial[DW-1:0];
        end
        dvd_d  = {dvd_q[VW-2:0], 1'b0};
        step_d = step_q + STW'(1);
        if (step_q == STW'(VW - 1)) begin
          state_d = lru3c_pkg::FR_PUSH;
        end
      end
      lru3c_pkg::FR_PUSH: begin
        if (!q_status_i.full) begin
          q_push_o = 1'b1;
          state_d  = lru3c_pkg::FR_IDLE;
        end
      end
      default: begin
        state_d = lru3c_pkg::FR_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lru3c_pkg::FR_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    dvd_q   <= dvd_d;
    div_q   <= div_d;
    rem_q   <= rem_d;
  end

  // The remainder is below the store size, so its low bits are the set.
  assign q_data_o = {value_q, rem_q[SIW-1:0]};
  assign busy_o   = (state_q != lru3c_pkg::FR_IDLE);

endmodule

### src/lru3c_back.sv
// ----------------------------------------------------------------------------
// lru3c_back
// Reads the set row, looks the value up, updates the LRU order and reports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lru3c_back #(
  parameter int MAX_SETS = 256,
  parameter int WAYS     = 3
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lru3c_pkg::q_status_t  q_status_i,
  input  logic [lru3c_pkg::VALUE_W+((MAX_SETS > 1) ? $clog2(MAX_SETS) : 1)-1:0] q_data_i,
  output logic                  q_pop_o,
  output logic                  clearing_o,
  output logic                  done_o,
  output logic [((MAX_SETS > 1) ? $clog2(MAX_SETS) : 1)-1:0] set_o,
  output lru3c_pkg::action_e    action_o
);

  localparam int VW    = lru3c_pkg::VALUE_W;
  localparam int SIW   = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int CW    = $clog2(WAYS + 1);
  localparam int ROW_W = CW + WAYS * VW;

  lru3c_pkg::back_state_e state_q, state_d;

  logic [SIW-1:0]   clr_q, clr_d;
  logic [VW-1:0]    value_q;
  logic [SIW-1:0]   set_q;
  logic [ROW_W-1:0] rd_row_q;
  logic [ROW_W-1:0] mem_q [MAX_SETS];

  logic             mem_we;
  logic [SIW-1:0]   mem_waddr;
  logic [ROW_W-1:0] mem_wdata;

  logic             done_q, done_d;
  logic [SIW-1:0]   set_out_q;
  lru3c_pkg::action_e act_q, act_d;

  // Row decode and update.
  logic [CW-1:0]    cnt;
  logic [VW-1:0]    way   [WAYS];
  logic [VW-1:0]    shft  [WAYS];
  logic [VW-1:0]    nway  [WAYS];
  logic             hit;
  logic [CW-1:0]    pos;
  logic [CW-1:0]    from_pos;
  logic [CW-1:0]    last_pos;
  logic [CW-1:0]    new_cnt;
  logic             upd_we;
  lru3c_pkg::action_e upd_act;
  logic [ROW_W-1:0] new_row;

  // Split the row into its count and ways; find the oldest matching way.
  always_comb begin
    cnt = rd_row_q[ROW_W-1 -: CW];
    hit = 1'b0;
    pos = '0;
    for (int i = 0; i < WAYS; i++) begin
      way[i] = rd_row_q[i*VW +: VW];
    end
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (CW'(i) < cnt && way[i] == value_q) begin
        hit = 1'b1;
        pos = CW'(i);
      end
    end
  end

  // Classify the access and pick the span of ways that rotates.
  always_comb begin
    from_pos = '0;
    last_pos = '0;
    new_cnt  = cnt;
    upd_we   = 1'b1;
    upd_act  = lru3c_pkg::ACT_FILL;
    if (cnt == '0) begin
      new_cnt = CW'(1);
    end else if (hit) begin
      if (pos == cnt - CW'(1)) begin
        upd_we  = 1'b0;
        upd_act = lru3c_pkg::ACT_HIT_NEWEST;
      end else begin
        from_pos = pos;
        last_pos = cnt - CW'(1);
        upd_act  = lru3c_pkg::ACT_HIT_REORDER;
      end
    end else if (cnt < CW'(WAYS)) begin
      from_pos = cnt;
      last_pos = cnt;
      new_cnt  = cnt + CW'(1);
      upd_act  = lru3c_pkg::ACT_APPEND;
    end else begin
      last_pos = CW'(WAYS - 1);
      upd_act  = lru3c_pkg::ACT_EVICT;
    end
  end

  // Ways in the span move one step toward the oldest end; the value lands last.
  always_comb begin
    for (int j = 0; j < WAYS - 1; j++) begin
      shft[j] = way[j+1];
    end
    shft[WAYS-1] = way[WAYS-1];
    for (int j = 0; j < WAYS; j++) begin
      if (CW'(j) == last_pos) begin
        nway[j] = value_q;
      end else if (CW'(j) >= from_pos && CW'(j) < last_pos) begin
        nway[j] = shft[j];
      end else begin
        nway[j] = way[j];
      end
    end
    new_row[ROW_W-1 -: CW] = new_cnt;
    for (int j = 0; j < WAYS; j++) begin
      new_row[j*VW +: VW] = nway[j];
    end
  end

  // Control: clearing pass after reset, then one item at a time.
  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    q_pop_o   = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = set_q;
    mem_wdata = new_row;
    done_d    = 1'b0;
    act_d     = act_q;
    case (state_q)
      lru3c_pkg::BK_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + SIW'(1);
        if (clr_q == SIW'(MAX_SETS - 1)) begin
          state_d = lru3c_pkg::BK_IDLE;
        end
      end
      lru3c_pkg::BK_IDLE: begin
        if (!q_status_i.empty) begin
          q_pop_o = 1'b1;
          state_d = lru3c_pkg::BK_LOOKUP;
        end
      end
      lru3c_pkg::BK_LOOKUP: begin
        mem_we  = upd_we;
        done_d  = 1'b1;
        act_d   = upd_act;
        state_d = lru3c_pkg::BK_IDLE;
      end
      default: begin
        state_d = lru3c_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lru3c_pkg::BK_CLEAR;
      clr_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      done_q  <= done_d;
    end
  end

  // Item and result payload.
  always_ff @(posedge clk_i) begin
    act_q <= act_d;
    if (q_pop_o) begin
      value_q <= q_data_i[SIW +: VW];
      set_q   <= q_data_i[SIW-1:0];
    end
    if (state_q == lru3c_pkg::BK_LOOKUP) begin
      set_out_q <= set_q;
    end
  end

  // Set row memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (q_pop_o) begin
      rd_row_q <= mem_q[q_data_i[SIW-1:0]];
    end
  end

  assign clearing_o = (state_q == lru3c_pkg::BK_CLEAR);
  assign done_o     = done_q;
  assign set_o      = set_out_q;
  assign action_o   = act_q;

  // A result strobe never lasts more than one cycle.
  `LRU3C_ASSERT(a_done_one_cycle, done_q |=> !done_q)
  // Every lookup produces exactly one result in the next cycle.
  `LRU3C_ASSERT(a_lookup_reports, (state_q == lru3c_pkg::BK_LOOKUP) |=> done_q)
  // The back never takes an item from an empty queue.
  `LRU3C_ASSERT_IMPL(a_pop_not_empty, q_pop_o, !q_status_i.empty)
  // A written row always holds between one and all ways.
  `LRU3C_ASSERT_IMPL(a_count_range, (state_q == lru3c_pkg::BK_LOOKUP) && mem_we,
                     (new_cnt != '0) && (new_cnt <= CW'(WAYS)))

endmodule

### src/three_way_lru_set_cache_core.sv
// ----------------------------------------------------------------------------
// three_way_lru_set_cache_core
// Set-associative value cache with LRU order inside each set.
// ----------------------------------------------------------------------------
// An item is taken when start_i is high and busy_o is low. One result follows
// per item as a single-cycle done_o strobe with set_index_o and action_o; the
// receiver cannot stall it, so it must capture the result in that cycle. An
// item occupies the front while it is accepted, through the 31 steps of the
// bit-serial remainder by the set count, and until it is handed to the queue,
// which waits while the queue is full; no new item is taken before that. Its
// result appears once the back has read and rewritten the set row. After
// reset the back clears the count of every set, one set per cycle, which
// keeps busy_o high until all are cleared; set count writes are taken at
// any time but should only be made while no item is in flight.
`timescale 1ns / 1ps

module three_way_lru_set_cache_core #(
  parameter int MAX_SETS = 256,
  parameter int WAYS     = 3
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  output logic                                  busy_o,
  input  logic [lru3c_pkg::VALUE_W-1:0]         value_i,
  input  logic                                  num_sets_we_i,
  input  logic [lru3c_pkg::NUM_SETS_W-1:0]      num_sets_i,
  output logic                                  done_o,
  output logic [lru3c_pkg::SET_INDEX_W-1:0]     set_index_o,
  output logic [lru3c_pkg::ACTION_W-1:0]        action_o
);

  localparam int VW  = lru3c_pkg::VALUE_W;
  localparam int SIW = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int QW  = VW + SIW;

  logic [lru3c_pkg::NUM_SETS_W-1:0] num_sets_q;

  logic                 accept;
  logic                 front_busy;
  logic                 clearing;
  logic                 q_push;
  logic                 q_pop;
  logic [QW-1:0]        q_wdata;
  logic [QW-1:0]        q_rdata;
  lru3c_pkg::q_status_t q_status;
  logic [SIW-1:0]       bk_set;
  lru3c_pkg::action_e   bk_action;
  logic [SIW+lru3c_pkg::SET_INDEX_W-1:0] set_ext;

  // Set count register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_sets_q <= lru3c_pkg::NUM_SETS_RST;
    end else if (num_sets_we_i) begin
      num_sets_q <= num_sets_i;
    end
  end

  // No item is taken while the front works or the set counts are cleared.
  assign busy_o = front_busy || clearing;
  assign accept = start_i && !busy_o;

  lru3c_front #(
    .MAX_SETS (MAX_SETS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .value_i    (value_i),
    .num_sets_i (num_sets_q),
    .q_status_i (q_status),
    .q_push_o   (q_push),
    .q_data_o   (q_wdata),
    .busy_o     (front_busy)
  );

  lru3c_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .pop_i       (q_pop),
    .pop_data_o  (q_rdata),
    .status_o    (q_status)
  );

  lru3c_back #(
    .MAX_SETS (MAX_SETS),
    .WAYS     (WAYS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_status_i (q_status),
    .q_data_i   (q_rdata),
    .q_pop_o    (q_pop),
    .clearing_o (clearing),
    .done_o     (done_o),
    .set_o      (bk_set),
    .action_o   (bk_action)
  );

  // The reported set index keeps its low bits only.
  assign set_ext     = {{lru3c_pkg::SET_INDEX_W{1'b0}}, bk_set};
  assign set_index_o = set_ext[lru3c_pkg::SET_INDEX_W-1:0];
  assign action_o    = bk_action;

endmodule
